FILE: rtl/tkmm_pkg.sv
package tkmm_pkg;

  localparam int ENTRIES = 20;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = 5;
  localparam int KEY_W = 16;
  localparam int ID_W = 29;
  localparam int DLC_W = 4;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 72;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [KEY_W-1:0] KEY_EMPTY = '1;

  typedef enum logic [0:0] {
    KIND_OFFER = 1'b0,
    KIND_DUMP  = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    ST_RUN  = 1'b0,
    ST_DUMP = 1'b1
  } bstate_t;

  typedef struct packed {
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] first_byte;
    logic [DLC_W-1:0]  data_length;
    logic [ID_W-1:0]   identifier;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef struct packed {
    kind_t kind;
    rec_t  rec;
  } cmd_t;

  // back end -> list storage
  typedef struct packed {
    logic             ins;
    logic             rd_list;
    logic [IDX_W-1:0] rd_idx;
  } lst_ctl_t;

endpackage

FILE: rtl/top_k_min_max_tracker.sv
// Offer: enters the input queue at the accept edge, is inserted when the back end pops it;
//   back end takes one offer per cycle while not dumping, no result word.
// Dump: first word passes the queue and the output register, then one word per cycle while
//   m_axis_tready is high, 2*ENTRIES words in all; the back end is busy until the last.
// Queue of two words lets input be taken while the back end is dumping.
// Synchronous active-high rst empties both lists and the queue.
module top_k_min_max_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_length, identifier, data_length, first_byte, second_byte, zero pad
  input  logic [71:0] s_axis_tdata,
  // action
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rank, entry_length, entry_identifier, entry_data_length,
  // entry_first_byte, entry_second_byte, zero pad
  output logic [71:0] m_axis_tdata,
  // which_list
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import tkmm_pkg::*;

  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_pop;
  lst_ctl_t          ctl;
  rec_t              ins_rec;
  rec_t              rd_rec;
  rec_t              out_rec;
  logic              out_which;
  logic [RANK_W-1:0] out_rank;

  tkmm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  tkmm_lists u_lists (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .ins_rec (ins_rec),
    .rd_rec  (rd_rec)
  );

  tkmm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .ctl       (ctl),
    .ins_rec   (ins_rec),
    .rd_rec    (rd_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec),
    .out_which (out_which),
    .out_rank  (out_rank),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_rec.tag.second_byte, out_rec.tag.first_byte,
                         out_rec.tag.data_length, out_rec.tag.identifier,
                         out_rec.key, out_rank};
  assign m_axis_tuser = out_which;

endmodule

FILE: rtl/tkmm_front.sv
module tkmm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tkmm_pkg::WORD_W-1:0] s_axis_tdata,
  input  logic [0:0]                  s_axis_tuser,
  output logic                        q_valid,
  output tkmm_pkg::cmd_t              q_cmd,
  input  logic                        q_pop
);
  import tkmm_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              in_cmd;

  // classify the incoming word
  always_comb begin
    in_cmd.kind = s_axis_tuser[0] ? KIND_DUMP : KIND_OFFER;
    in_cmd.rec.key = s_axis_tdata[15:0];
    in_cmd.rec.tag.identifier = s_axis_tdata[44:16];
    in_cmd.rec.tag.data_length = s_axis_tdata[48:45];
    in_cmd.rec.tag.first_byte = s_axis_tdata[56:49];
    in_cmd.rec.tag.second_byte = s_axis_tdata[64:57];
  end

  assign s_axis_tready = (count != QCNT_W'(QDEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_cmd = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/tkmm_lists.sv
module tkmm_lists (
  input  logic               clk,
  input  logic               rst,
  input  tkmm_pkg::lst_ctl_t ctl,
  input  tkmm_pkg::rec_t     ins_rec,
  output tkmm_pkg::rec_t     rd_rec
);
  import tkmm_pkg::*;

  rec_t               s_rec [ENTRIES];
  rec_t               l_rec [ENTRIES];
  logic [ENTRIES-1:0] s_vld;
  rec_t               s_up [ENTRIES];
  rec_t               l_up [ENTRIES];
  rec_t               s_rec_next [ENTRIES];
  rec_t               l_rec_next [ENTRIES];
  logic [ENTRIES-1:0] s_vld_next;
  logic [ENTRIES-1:0] s_gt;
  logic [ENTRIES-1:0] l_gt;
  logic [ENTRIES-1:0] s_gt_prev;
  logic [ENTRIES-1:0] l_gt_prev;
  logic [ENTRIES-1:0] s_vld_up;

  // each slot compares itself; lists are sorted so the hits form a suffix
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      s_gt[i] = !s_vld[i] || (ins_rec.key < s_rec[i].key);
      l_gt[i] = ins_rec.key > l_rec[i].key;
    end
  end

  assign s_gt_prev = s_gt << 1;
  assign l_gt_prev = l_gt << 1;
  assign s_vld_up = s_vld << 1;

  always_comb begin
    s_up[0] = ins_rec;
    l_up[0] = ins_rec;
    for (int i = 1; i < ENTRIES; i++) begin
      s_up[i] = s_rec[i-1];
      l_up[i] = l_rec[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      s_rec_next[i] = s_rec[i];
      l_rec_next[i] = l_rec[i];
      s_vld_next[i] = s_vld[i];
      if (s_gt[i]) begin
        s_rec_next[i] = s_gt_prev[i] ? s_up[i] : ins_rec;
        s_vld_next[i] = s_gt_prev[i] ? s_vld_up[i] : 1'b1;
      end
      if (l_gt[i]) begin
        l_rec_next[i] = l_gt_prev[i] ? l_up[i] : ins_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        s_rec[i].key <= KEY_EMPTY;
        s_rec[i].tag <= '0;
        l_rec[i] <= '0;
      end
    end else if (ctl.ins) begin
      s_vld <= s_vld_next;
      for (int i = 0; i < ENTRIES; i++) begin
        s_rec[i] <= s_rec_next[i];
        l_rec[i] <= l_rec_next[i];
      end
    end
  end

  assign rd_rec = ctl.rd_list ? l_rec[ctl.rd_idx] : s_rec[ctl.rd_idx];

endmodule

FILE: rtl/tkmm_back.sv
module tkmm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  tkmm_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output tkmm_pkg::lst_ctl_t          ctl,
  output tkmm_pkg::rec_t              ins_rec,
  input  tkmm_pkg::rec_t              rd_rec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tkmm_pkg::rec_t              out_rec,
  output logic                        out_which,
  output logic [tkmm_pkg::RANK_W-1:0] out_rank,
  output logic                        out_last
);
  import tkmm_pkg::*;

  bstate_t          state;
  bstate_t          state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             which;
  logic             which_next;
  logic             out_load;
  logic             at_end;

  assign ins_rec = q_cmd.rec;
  assign at_end = (idx == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_next = state;
    idx_next = idx;
    which_next = which;
    q_pop = 1'b0;
    out_load = 1'b0;
    ctl.ins = 1'b0;
    ctl.rd_list = which;
    ctl.rd_idx = idx;
    unique case (state)
      ST_RUN: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.kind == KIND_DUMP) begin
            state_next = ST_DUMP;
            idx_next = '0;
            which_next = 1'b0;
          end else begin
            ctl.ins = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (at_end) begin
            idx_next = '0;
            which_next = !which;
            if (which) begin
              state_next = ST_RUN;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      idx <= '0;
      which <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      which <= which_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rec <= rd_rec;
      out_which <= which;
      out_rank <= RANK_W'(idx);
      out_last <= which && at_end;
    end
  end

endmodule

FILE: rtl/tkmm_checker.sv
module tkmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import tkmm_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_last_list: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("last word not from largest list");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[4:0] <= RANK_W'(ENTRIES - 1)))
    else $error("rank out of range");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tlast == (m_axis_tdata[4:0] == RANK_W'(ENTRIES - 1))))
    else $error("last flag does not match final rank");

endmodule

bind top_k_min_max_tracker tkmm_checker u_tkmm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tkmm_pkg::*;

  localparam int LIST_LO = 0;
  localparam int LIST_HI = 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic       lst;
    logic [4:0] rank;
    rec_t       rec;
    logic       is_last;
  } dump_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  top_k_min_max_tracker u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted list contents: [0] smallest keys, [1] largest keys
  rec_t       held [2][ENTRIES];
  int         lo_fill;
  dump_word_t dump_words_due[$];
  cmd_t       feed_q[$];

  int   queued = 0;
  int   taken = 0;
  int   dumps_taken = 0;
  int   words_checked = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic in_fire = 1'b0;
  logic steady = 1'b0;
  logic hold_go = 1'b0;
  cmd_t next_cmd;
  dump_word_t got_word;
  dump_word_t want_word;

  function automatic rec_t make_rec(int unsigned key, int unsigned id, int unsigned dlc,
                                    int unsigned b1, int unsigned b2);
    rec_t r;
    r.key = key[KEY_W-1:0];
    r.tag.identifier = id[ID_W-1:0];
    r.tag.data_length = dlc[DLC_W-1:0];
    r.tag.first_byte = b1[BYTE_W-1:0];
    r.tag.second_byte = b2[BYTE_W-1:0];
    return r;
  endfunction

  function automatic rec_t random_rec();
    int unsigned pick;
    int unsigned key;
    int unsigned dlc;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      key = $urandom_range(0, 16'hFFFF);
    end else if (pick < 7) begin
      key = 16'd1000 + $urandom_range(0, 7);    // tie cluster, low end
    end else if (pick < 8) begin
      key = 16'hFF00 + $urandom_range(0, 3);    // tie cluster, high end
    end else begin
      case ($urandom_range(0, 3))
        0: key = 0;
        1: key = 1;
        2: key = 16'hFFFE;
        default: key = 16'hFFFF;
      endcase
    end
    dlc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    return make_rec(key, $urandom, dlc, $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  function automatic void insert_at(int l, int pos, rec_t r);
    for (int j = ENTRIES - 1; j > pos; j--) held[l][j] = held[l][j-1];
    held[l][pos] = r;
  endfunction

  function automatic void track_offer(rec_t r);
    int pos;
    // equal keys land behind the stored ones
    if (lo_fill < ENTRIES || r.key < held[LIST_LO][ENTRIES-1].key) begin
      pos = 0;
      while (pos < lo_fill && !(r.key < held[LIST_LO][pos].key)) pos++;
      insert_at(LIST_LO, pos, r);
      if (lo_fill < ENTRIES) lo_fill++;
    end
    if (r.key > held[LIST_HI][ENTRIES-1].key) begin
      pos = 0;
      while (!(r.key > held[LIST_HI][pos].key)) pos++;
      insert_at(LIST_HI, pos, r);
    end
  endfunction

  function automatic void queue_dump_words();
    dump_word_t w;
    for (int l = LIST_LO; l <= LIST_HI; l++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        w.lst = l[0];
        w.rank = i[4:0];
        w.rec = held[l][i];
        w.is_last = (l == LIST_HI && i == ENTRIES - 1);
        dump_words_due.push_back(w);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("word %0d %s: got 0x%0h, want 0x%0h",
                                words_checked, name, got, want));
  endtask

  task automatic check_word(dump_word_t got, dump_word_t want);
    check_field("list", got.lst, want.lst);
    check_field("rank", got.rank, want.rank);
    check_field("length", got.rec.key, want.rec.key);
    check_field("identifier", got.rec.tag.identifier, want.rec.tag.identifier);
    check_field("data length", got.rec.tag.data_length, want.rec.tag.data_length);
    check_field("first byte", got.rec.tag.first_byte, want.rec.tag.first_byte);
    check_field("second byte", got.rec.tag.second_byte, want.rec.tag.second_byte);
    check_field("last", got.is_last, want.is_last);
  endtask

  task automatic push_offer(rec_t r);
    cmd_t c;
    c.kind = KIND_OFFER;
    c.rec = r;
    feed_q.push_back(c);
    queued++;
  endtask

  task automatic push_dump();
    cmd_t c;
    c.kind = KIND_DUMP;
    c.rec = random_rec();   // payload is don't-care on a dump
    feed_q.push_back(c);
    queued++;
  endtask

  task automatic push_random(int n, int dump_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < dump_pct) push_dump();
      else push_offer(random_rec());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (taken != queued || dump_words_due.size() != 0);
  endtask

  // sender: next word goes out once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (feed_q.size() > 0 && (steady || $urandom_range(0, 99) >= 17)) begin
        next_cmd = feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, next_cmd.rec};
        s_axis_tuser <= next_cmd.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (hold_go || hold_left > 1) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        taken <= taken + 1;
        if (kind_t'(s_axis_tuser) == KIND_DUMP) begin
          queue_dump_words();
          dumps_taken <= dumps_taken + 1;
        end else begin
          track_offer(rec_t'(s_axis_tdata[64:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.lst = m_axis_tuser[0];
        got_word.rank = m_axis_tdata[4:0];
        got_word.rec = rec_t'(m_axis_tdata[69:5]);
        got_word.is_last = m_axis_tlast;
        if (dump_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word, list %0d rank %0d",
                                    got_word.lst, got_word.rank));
        end else begin
          want_word = dump_words_due.pop_front();
          check_word(got_word, want_word);
        end
        words_checked++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles, %0d words still due",
                   STALL_LIMIT, dump_words_due.size());
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      held[LIST_LO][i] = '0;
      held[LIST_LO][i].key = KEY_EMPTY;
      held[LIST_HI][i] = '0;
    end
    lo_fill = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dump, key extremes, field extremes, ties
    push_dump();
    push_offer(make_rec(16'hFFFF, 29'h1FFFFFFF, 15, 8'hFF, 8'hFF));
    push_offer(make_rec(16'h0000, 0, 0, 0, 0));
    push_offer(make_rec(500, 29'h0000_0A1, 1, 8'h11, 8'h22));
    push_offer(make_rec(500, 29'h0000_0B2, 2, 8'h33, 8'h44));
    push_offer(make_rec(500, 29'h0000_0C3, 3, 8'h55, 8'h66));
    push_offer(make_rec(1, 29'h0AAAAAAA, 8, 8'h55, 8'hAA));
    push_offer(make_rec(16'hFFFE, 29'h15555555, 7, 8'hAA, 8'h55));
    push_offer(make_rec(16'h8000, 29'h10000000, 8, 8'h80, 8'h01));
    push_dump();
    push_offer(make_rec(0, 29'h1234567, 4, 8'h01, 8'h80));
    push_offer(make_rec(16'hFFFF, 29'h7654321, 12, 8'hC3, 8'h3C));
    push_dump();
    wait_drained();

    @(posedge clk);
    push_random(60, 8);
    wait_drained();

    // stretch without any idling
    @(posedge clk);
    steady <= 1'b1;
    push_random(50, 8);
    wait_drained();

    // receiver holds off while a dump and a burst of offers pile up behind it
    @(posedge clk);
    hold_go <= 1'b1;
    push_dump();
    for (int i = 0; i < 12; i++) push_offer(random_rec());
    push_dump();
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    @(posedge clk);
    steady <= 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int i = $urandom_range(15, 25); i > 0; i--) push_offer(random_rec());
      push_dump();
    end
    push_random(12, 15);
    push_dump();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input words (%0d dumps) with random stalls and a long hold-off;",
             taken, dumps_taken);
    $display("%0d list entries compared, %0d field errors", words_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
